### rtl/bcc_pkg.sv
// bcc_pkg: shared types, widths, constants and joystick tables for the balance controller
// no dependencies; imported by every rtl module of the block

package bcc_pkg;

    // signal and gain formats
    localparam int SIG_W          = 24;
    localparam int FRAC_BITS      = 12;
    localparam int GAIN_FRAC_BITS = 20;

    // fixed field widths
    localparam int GAIN_W  = 24;
    localparam int OFS_W   = 24;
    localparam int LIM_W   = 23;
    localparam int CFG_W   = 24;
    localparam int JOY_W   = 8;
    localparam int CFG_IDX_W = 3;

    // joystick scaling and wheel spin threshold
    localparam int JOY_CENTER = 128;
    localparam int JOY_DEPTH  = 2 ** JOY_W;
    localparam int CMD_DIV    = 10;
    localparam int TURN_DIV   = 2000;
    localparam int SPIN_NUM   = 314;
    localparam int SPIN_DEN   = 100;
    localparam int SPIN       = ((SPIN_NUM << FRAC_BITS) + SPIN_DEN / 2) / SPIN_DEN;

    // derived datapath widths
    localparam int CMD_W    = FRAC_BITS + 6;
    localparam int TILT_W   = ((SIG_W > OFS_W) ? SIG_W : OFS_W) + 1;
    localparam int ERR_W    = ((CMD_W > SIG_W) ? CMD_W : SIG_W) + 1;
    localparam int MUL_A_W  = ((TILT_W + 1) > ERR_W) ? (TILT_W + 1) : ERR_W;
    localparam int PROD_W   = MUL_A_W + GAIN_W + 1;
    localparam int ROUND_W  = PROD_W - GAIN_FRAC_BITS;
    localparam int WIDE_W   = ROUND_W + 2;
    localparam int CMP_W    = (TILT_W > LIM_W) ? TILT_W : LIM_W;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PICKED  = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PITCH_OFFSET   = 3'd0,
        REG_ANGLE_GAIN_P   = 3'd1,
        REG_ANGLE_GAIN_D   = 3'd2,
        REG_SPEED_GAIN_P   = 3'd3,
        REG_SPEED_GAIN_I   = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_UPRIGHT_WINDOW = 3'd6,
        REG_FALL_LIMIT     = 3'd7
    } cfg_idx_t;

    // register reset values
    localparam logic signed [OFS_W-1:0] RST_PITCH_OFFSET   = -24'sd4096;
    localparam logic [GAIN_W-1:0]       RST_ANGLE_GAIN_P   = 24'd33030;
    localparam logic [GAIN_W-1:0]       RST_ANGLE_GAIN_D   = 24'd1573;
    localparam logic [GAIN_W-1:0]       RST_SPEED_GAIN_P   = 24'd1363149;
    localparam logic [GAIN_W-1:0]       RST_SPEED_GAIN_I   = 24'd3670;
    localparam logic [LIM_W-1:0]        RST_INTEGRAL_LIMIT = 23'd61440;
    localparam logic [LIM_W-1:0]        RST_UPRIGHT_WINDOW = 23'd2048;
    localparam logic [LIM_W-1:0]        RST_FALL_LIMIT     = 23'd204800;

    typedef struct packed {
        logic signed [OFS_W-1:0] pitch_offset;
        logic [GAIN_W-1:0]       angle_gain_p;
        logic [GAIN_W-1:0]       angle_gain_d;
        logic [GAIN_W-1:0]       speed_gain_p;
        logic [GAIN_W-1:0]       speed_gain_i;
        logic [LIM_W-1:0]        integral_limit;
        logic [LIM_W-1:0]        upright_window;
        logic [LIM_W-1:0]        fall_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] pitch_angle;
        logic signed [SIG_W-1:0] pitch_rate;
        logic signed [SIG_W-1:0] wheel_speed_right;
        logic signed [SIG_W-1:0] wheel_speed_left;
        logic [JOY_W-1:0]        joy_x;
        logic [JOY_W-1:0]        joy_y;
    } in_word_t;

    typedef struct packed {
        logic signed [SIG_W-1:0] drive_left;
        logic signed [SIG_W-1:0] drive_right;
        mode_t                   mode;
    } out_word_t;

    typedef enum logic [1:0] {
        MUL_ERR_I   = 2'd0,
        MUL_ERR_P   = 2'd1,
        MUL_ANGLE_P = 2'd2,
        MUL_RATE_D  = 2'd3
    } mul_sel_t;

    // tick sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL_I,
        ST_MUL_P,
        ST_TARGET,
        ST_MUL_A,
        ST_MUL_D,
        ST_SUM,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic     load_in;
        logic     eval;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     upd_integral;
        logic     upd_target;
        logic     upd_acc;
        logic     upd_drive;
        logic     load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic run_path;
    } dp_status_t;

    typedef logic signed [CMD_W-1:0] joy_tab_t [JOY_DEPTH];

    // speed command per joystick byte, rounded to nearest with ties away from zero
    function automatic joy_tab_t build_cmd_tab();
        joy_tab_t tab;
        int       i;
        int       d;
        int       mag;
        int       r;
        for (i = 0; i < JOY_DEPTH; i++) begin
            d      = JOY_CENTER - i;
            mag    = ((d < 0) ? -d : d) << FRAC_BITS;
            r      = (mag + CMD_DIV / 2) / CMD_DIV;
            tab[i] = CMD_W'((d < 0) ? -r : r);
        end
        return tab;
    endfunction

    // turn command per joystick byte, same rounding
    function automatic joy_tab_t build_turn_tab();
        joy_tab_t tab;
        int       i;
        int       d;
        int       mag;
        int       r;
        for (i = 0; i < JOY_DEPTH; i++) begin
            d      = JOY_CENTER - i;
            mag    = ((d < 0) ? -d : d) << FRAC_BITS;
            r      = (mag + TURN_DIV / 2) / TURN_DIV;
            tab[i] = CMD_W'((d < 0) ? -r : r);
        end
        return tab;
    endfunction

    localparam joy_tab_t CMD_TAB  = build_cmd_tab();
    localparam joy_tab_t TURN_TAB = build_turn_tab();

endpackage

### rtl/bcc_cfg_regs.sv
// bcc_cfg_regs: configuration register file with index decode and reset values
// depends on bcc_pkg

module bcc_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_data,
    output bcc_pkg::cfg_t                 cfg
);
    import bcc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_PITCH_OFFSET:   cfg_next.pitch_offset   = $signed(cfg_data[OFS_W-1:0]);
                REG_ANGLE_GAIN_P:   cfg_next.angle_gain_p   = cfg_data[GAIN_W-1:0];
                REG_ANGLE_GAIN_D:   cfg_next.angle_gain_d   = cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN_P:   cfg_next.speed_gain_p   = cfg_data[GAIN_W-1:0];
                REG_SPEED_GAIN_I:   cfg_next.speed_gain_i   = cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: cfg_next.integral_limit = cfg_data[LIM_W-1:0];
                REG_UPRIGHT_WINDOW: cfg_next.upright_window = cfg_data[LIM_W-1:0];
                REG_FALL_LIMIT:     cfg_next.fall_limit     = cfg_data[LIM_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pitch_offset   <= RST_PITCH_OFFSET;
            cfg_reg.angle_gain_p   <= RST_ANGLE_GAIN_P;
            cfg_reg.angle_gain_d   <= RST_ANGLE_GAIN_D;
            cfg_reg.speed_gain_p   <= RST_SPEED_GAIN_P;
            cfg_reg.speed_gain_i   <= RST_SPEED_GAIN_I;
            cfg_reg.integral_limit <= RST_INTEGRAL_LIMIT;
            cfg_reg.upright_window <= RST_UPRIGHT_WINDOW;
            cfg_reg.fall_limit     <= RST_FALL_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/bcc_ctrl.sv
// bcc_ctrl: tick sequencer that steps the datapath through mode update and gain products
// depends on bcc_pkg; drives bcc_datapath through dp_cmd_t

module bcc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    output logic                out_valid,
    input  logic                out_stall,
    input  bcc_pkg::dp_status_t status,
    output bcc_pkg::dp_cmd_t    cmd
);
    import bcc_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        in_stall       = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = status.run_path ? ST_MUL_I : ST_DONE;
            end
            ST_MUL_I:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ERR_I;
                state_next  = ST_MUL_P;
            end
            ST_MUL_P:
            begin
                cmd.mul_en       = 1'b1;
                cmd.mul_sel      = MUL_ERR_P;
                cmd.upd_integral = 1'b1;
                state_next       = ST_TARGET;
            end
            ST_TARGET:
            begin
                cmd.upd_target = 1'b1;
                state_next     = ST_MUL_A;
            end
            ST_MUL_A:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_ANGLE_P;
                state_next  = ST_MUL_D;
            end
            ST_MUL_D:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_RATE_D;
                cmd.upd_acc = 1'b1;
                state_next  = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.upd_drive = 1'b1;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                // wait for the output register to free up
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/bcc_datapath.sv
// bcc_datapath: mode state, speed integral, shared gain multiplier and drive saturation
// depends on bcc_pkg; sequenced by bcc_ctrl through dp_cmd_t

module bcc_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bcc_pkg::cfg_t       cfg,
    input  bcc_pkg::dp_cmd_t    cmd,
    output bcc_pkg::dp_status_t status,
    input  bcc_pkg::in_word_t   in_data,
    output bcc_pkg::out_word_t  out_data
);
    import bcc_pkg::*;

    typedef logic signed [WIDE_W-1:0] wide_t;

    localparam wide_t SIG_MAX_W = WIDE_W'((longint'(1) <<< (SIG_W - 1)) - 1);
    localparam wide_t SIG_MIN_W = -SIG_MAX_W - WIDE_W'(1);
    localparam wide_t SPIN_W    = WIDE_W'(SPIN);
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (GAIN_FRAC_BITS - 1));
    localparam int SUM_W = SIG_W + 1;

    function automatic logic signed [SIG_W-1:0] sat_sig(input wide_t v);
        wide_t r;
        r = v;
        if (v > SIG_MAX_W)
            r = SIG_MAX_W;
        else if (v < SIG_MIN_W)
            r = SIG_MIN_W;
        return r[SIG_W-1:0];
    endfunction

    // captured word and per-tick intermediates
    in_word_t                  in_reg;
    logic signed [TILT_W-1:0]  tilt_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [CMD_W-1:0]   turn_reg;
    logic signed [SIG_W-1:0]   target_reg;
    logic signed [ROUND_W-1:0] acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    out_word_t                 out_reg;

    // architectural state
    mode_t                     mode_reg;
    mode_t                     mode_next;
    logic signed [SIG_W-1:0]   integral_reg;
    logic signed [SIG_W-1:0]   integral_next;
    logic signed [SIG_W-1:0]   held_left_reg;
    logic signed [SIG_W-1:0]   held_left_next;
    logic signed [SIG_W-1:0]   held_right_reg;
    logic signed [SIG_W-1:0]   held_right_next;

    logic signed [TILT_W-1:0]  tilt_next;
    logic [TILT_W-1:0]         tilt_abs;
    logic                      below_window;
    logic                      over_fall;
    logic                      spin_seen;
    logic signed [SUM_W-1:0]   speed_sum;
    logic signed [SIG_W-1:0]   speed_avg;
    logic signed [CMD_W-1:0]   cmd_val;
    logic signed [CMD_W-1:0]   turn_next;
    logic signed [ERR_W-1:0]   err_next;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_biased;
    logic signed [ROUND_W-1:0] prod_round;
    logic signed [SIG_W-1:0]   target_next;
    logic signed [ROUND_W-1:0] acc_next;
    wide_t                     int_sum;
    wide_t                     int_lim;
    wide_t                     int_clamped;
    wide_t                     pd_sum;

    // tilt and mode conditions from the captured word
    assign tilt_next    = TILT_W'(in_reg.pitch_angle) - TILT_W'(cfg.pitch_offset);
    assign tilt_abs     = tilt_next[TILT_W-1] ? TILT_W'(-tilt_next) : TILT_W'(tilt_next);
    assign below_window = CMP_W'(tilt_abs) < CMP_W'(cfg.upright_window);
    assign over_fall    = CMP_W'(tilt_abs) > CMP_W'(cfg.fall_limit);
    assign spin_seen    = (WIDE_W'(in_reg.wheel_speed_right) > SPIN_W)
                       && (WIDE_W'(in_reg.wheel_speed_left) < -SPIN_W);

    // speed error: floor average of both wheels against the joystick command
    assign speed_sum = SUM_W'(in_reg.wheel_speed_right) + SUM_W'(in_reg.wheel_speed_left);
    assign speed_avg = speed_sum[SUM_W-1:1];
    assign cmd_val   = CMD_TAB[in_reg.joy_y];
    assign turn_next = TURN_TAB[in_reg.joy_x];
    assign err_next  = ERR_W'(cmd_val) - ERR_W'(speed_avg);

    assign status.run_path = (mode_reg == MODE_RUNNING) && !over_fall;

    // shared gain multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MUL_ERR_I:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = cfg.speed_gain_i;
            end
            MUL_ERR_P:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = cfg.speed_gain_p;
            end
            MUL_ANGLE_P:
            begin
                mul_a = MUL_A_W'(tilt_reg) - MUL_A_W'(target_reg);
                mul_b = cfg.angle_gain_p;
            end
            MUL_RATE_D:
            begin
                mul_a = MUL_A_W'(in_reg.pitch_rate);
                mul_b = cfg.angle_gain_d;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

    // round half up, then drop the gain fraction
    assign prod_biased = prod_reg + ROUND_HALF;
    assign prod_round  = prod_biased[PROD_W-1:GAIN_FRAC_BITS];

    assign target_next = sat_sig(WIDE_W'(prod_round) + WIDE_W'(integral_reg));
    assign acc_next    = prod_round;

    assign int_sum     = WIDE_W'(integral_reg) + WIDE_W'(prod_round);
    assign int_lim     = $signed(WIDE_W'(cfg.integral_limit));
    assign int_clamped = (int_sum < -int_lim) ? -int_lim
                       : ((int_sum > int_lim) ? int_lim : int_sum);

    assign pd_sum = WIDE_W'(acc_reg) + WIDE_W'(prod_round);

    always_comb
    begin
        mode_next       = mode_reg;
        integral_next   = integral_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        if (cmd.eval)
        begin
            unique case (mode_reg)
                MODE_STOPPED:
                begin
                    if (below_window)
                        mode_next = MODE_RUNNING;
                end
                MODE_RUNNING:
                begin
                    // fall: clear the integral, drives keep their held values
                    if (over_fall)
                    begin
                        integral_next = '0;
                        mode_next     = MODE_PICKED;
                    end
                end
                default:
                begin
                    // picked up, and the unused code acting as picked up
                    held_left_next  = '0;
                    held_right_next = '0;
                    mode_next       = spin_seen ? MODE_STOPPED : MODE_PICKED;
                end
            endcase
        end
        if (cmd.upd_integral)
            integral_next = sat_sig(int_clamped);
        if (cmd.upd_drive)
        begin
            held_left_next  = sat_sig(pd_sum + WIDE_W'(turn_reg));
            held_right_next = sat_sig(pd_sum - WIDE_W'(turn_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_PICKED;
            integral_reg   <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            integral_reg   <= integral_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= in_data;
        if (cmd.eval)
        begin
            tilt_reg <= tilt_next;
            err_reg  <= err_next;
            turn_reg <= turn_next;
        end
        if (cmd.mul_en)
            prod_reg <= prod_next;
        if (cmd.upd_target)
            target_reg <= target_next;
        if (cmd.upd_acc)
            acc_reg <= acc_next;
        if (cmd.load_out)
        begin
            out_reg.drive_left  <= held_left_reg;
            out_reg.drive_right <= held_right_reg;
            out_reg.mode        <= mode_reg;
        end
    end

    assign out_data = out_reg;

endmodule

### rtl/balance_cascade_controller_core.sv
// balance_cascade_controller_core: top level of the cascaded pi/pd balance controller
// depends on bcc_pkg, bcc_cfg_regs, bcc_ctrl and bcc_datapath
//
// channel   direction  handshake            word
// --------  ---------  -------------------  -----------------------------------------
// in        sink       in_valid / in_stall  pitch, rate, both wheel speeds, joystick
// out       source     out_valid/out_stall  left drive, right drive, mode after tick
// cfg       sink       cfg_we               cfg_index selects one of eight registers
//
// a running tick goes from accept to result through capture, mode evaluation,
// four products through the one shared gain multiplier, then sums and saturation
// a stopped, picked up or falling tick goes through capture, evaluation and output load
// the next word is taken in the cycle after the result is loaded into the output register
// a stalled result holds in the output register; a tick finishing behind it waits
// reset clears mode to picked up, the speed integral and held drives, and loads
// the register defaults; no clearing pass is needed

module balance_cascade_controller_core (
    input  logic                          clk,
    input  logic                          rst_n,
    // input words
    input  logic                          in_valid,
    output logic                          in_stall,
    input  bcc_pkg::in_word_t             in_data,
    // result words
    output logic                          out_valid,
    input  logic                          out_stall,
    output bcc_pkg::out_word_t            out_data,
    // configuration writes
    input  logic                          cfg_we,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);
    import bcc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    // gains, offset, clamps and mode thresholds
    bcc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer: owns both handshakes and the output valid flag
    bcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // mode state, integral, multiplier and output register
    bcc_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cmd      (cmd),
        .status   (status),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

### rtl/bcc_checker.sv
// bcc_checker: port-level assertions for the balance controller, bound to the top level
// depends on bcc_pkg and balance_cascade_controller_core

module bcc_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input bcc_pkg::out_word_t out_data
);
    import bcc_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result word changed");

    // one tick at a time: an accepted word makes the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again while a tick is in work");

    // a result only appears at the end of a tick in work
    a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result word without a tick in work");

    // stopped is only reached from picked up, so its drives are zero
    a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.mode == MODE_STOPPED)
            |-> (out_data.drive_left == '0) && (out_data.drive_right == '0))
        else $error("nonzero drive in stopped mode");

endmodule

bind balance_cascade_controller_core bcc_checker u_bcc_checker (.*);
